### hw/rtl/sida_pkg.sv
// shared types and constants for the signed integer to decimal ascii converter
`timescale 1ns / 1ps
`default_nettype none
package sida_pkg;

	// default width of the signed input value
	localparam int VALUE_BITS_DEF = 32;

	// ascii codes
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture value, form magnitude, clear bcd
		logic step;      // two double-dabble bit steps
		logic find;      // locate most significant nonzero digit
		logic ld_minus;  // load '-' into output register
		logic ld_digit;  // load current digit into output register
	} sida_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic neg;       // captured value was negative
		logic idx_zero;  // digit pointer is at the least significant digit
	} sida_status_t;

endpackage
`default_nettype wire

### hw/rtl/sida_dp.sv
// datapath: magnitude, shift-add-3 binary to bcd, digit pointer and output register
`timescale 1ns / 1ps
`default_nettype none
module sida_dp #(
	parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [VALUE_BITS-1:0]   value,
	input  wire sida_pkg::sida_cmd_t     cmd,
	output sida_pkg::sida_status_t       status,
	output logic [7:0]                   character,
	output logic                         last
);
	import sida_pkg::*;

	localparam int STEPS = (VALUE_BITS + 1) / 2;
	localparam int MAGW  = 2 * STEPS;
	localparam int ND    = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCDW  = 4 * ND;
	localparam int IDXW  = $clog2(ND);

	logic [MAGW-1:0]       mag_q;
	logic [BCDW-1:0]       bcd_q;
	logic                  neg_q;
	logic [IDXW-1:0]       idx_q;
	logic [7:0]            char_q;
	logic                  last_q;

	logic [VALUE_BITS-1:0] mag_abs;
	logic [BCDW-1:0]       bcd_one;
	logic [BCDW-1:0]       bcd_two;
	logic [IDXW-1:0]       top_idx;
	logic [3:0]            cur_digit;

	// one shift-add-3 bit step over all digits
	function automatic logic [BCDW-1:0] dabble(input logic [BCDW-1:0] bcd, input logic bit_in);
		logic [BCDW-1:0] adj;
		adj = bcd;
		for (int i = 0; i < ND; i++) begin
			if (bcd[4*i +: 4] > 4'd4) begin
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end
		end
		return {adj[BCDW-2:0], bit_in};
	endfunction

	// magnitude as unsigned, exact for the most negative value
	assign mag_abs = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

	// two bit steps per cycle, msb of magnitude first
	assign bcd_one = dabble(bcd_q, mag_q[MAGW-1]);
	assign bcd_two = dabble(bcd_one, mag_q[MAGW-2]);

	// highest nonzero digit, zero when all digits are zero
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				top_idx = IDXW'(i);
			end
		end
	end

	assign cur_digit = bcd_q[4*idx_q +: 4];

	// conversion registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= MAGW'(mag_abs);
			neg_q <= value[VALUE_BITS-1];
			bcd_q <= '0;
		end else if (cmd.step) begin
			mag_q <= {mag_q[MAGW-3:0], 2'b00};
			bcd_q <= bcd_two;
		end
	end

	// digit pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.find) begin
			idx_q <= top_idx;
		end else if (cmd.ld_digit) begin
			idx_q <= idx_q - IDXW'(1);
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.ld_minus) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.ld_digit) begin
			char_q <= CHAR_ZERO + {4'b0000, cur_digit};
			last_q <= (idx_q == '0);
		end
	end

	assign status.neg      = neg_q;
	assign status.idx_zero = (idx_q == '0);
	assign character       = char_q;
	assign last            = last_q;

endmodule
`default_nettype wire

### hw/rtl/sida_ctrl.sv
// controller: sequences load, conversion, digit search and character output
`timescale 1ns / 1ps
`default_nettype none
module sida_ctrl #(
	parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	input  wire sida_pkg::sida_status_t status,
	output sida_pkg::sida_cmd_t         cmd
);
	import sida_pkg::*;

	localparam int STEPS = (VALUE_BITS + 1) / 2;
	localparam int CNTW  = $clog2(STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_EMIT
	} state_t;

	state_t          state_q;
	logic [CNTW-1:0] cnt_q;
	logic            minus_q;
	logic            valid_q;
	logic            out_free;
	logic            in_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !valid_q || out_ready;

	// commands decoded from state
	always_comb begin
		cmd          = '0;
		cmd.load     = in_fire;
		cmd.step     = (state_q == ST_CONV);
		cmd.find     = (state_q == ST_FIND);
		cmd.ld_minus = (state_q == ST_EMIT) && out_free && minus_q;
		cmd.ld_digit = (state_q == ST_EMIT) && out_free && !minus_q;
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			minus_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			// output transaction taken with nothing new behind it
			if (valid_q && out_ready && (state_q != ST_EMIT)) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_fire) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(STEPS - 1)) begin
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					minus_q <= status.neg;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						valid_q <= 1'b1;
						if (minus_q) begin
							minus_q <= 1'b0;
						end else if (status.idx_zero) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = valid_q;

endmodule
`default_nettype wire

### hw/rtl/signed_int_to_decimal_ascii_top.sv
// top level of the signed integer to decimal ascii converter
//
// channel   dir   handshake          payload
// s_*       in    s_tvalid/s_tready  s_tdata: value
// m_*       out   m_tvalid/m_tready  m_tdata: character, m_tlast: last
//
// a value is taken on an s_* handshake, then converted by shift-add-3 at two
// bits per cycle, and then the leading digit is found; characters then leave
// one per cycle while m_tready allows, up to 11 for 32 bits
// one value at a time: s_tready is high only while no conversion is running,
// and the next value may enter while the final character still waits in m_tdata
// reset clears the controller and the output valid; m_tready low simply holds
// the current character
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_ascii_top #(
	parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,   // value
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [7:0]                             m_tdata,   // character
	output logic                                   m_tlast
);
	import sida_pkg::*;

	sida_cmd_t    cmd;
	sida_status_t status;

	// sequencing
	sida_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// conversion and output payload
	sida_dp #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.value    (s_tdata[VALUE_BITS-1:0]),
		.cmd      (cmd),
		.status   (status),
		.character(m_tdata),
		.last     (m_tlast)
	);

endmodule
`default_nettype wire

### tb/sv/tb_signed_int_to_decimal_ascii_top.sv
// testbench for the signed integer to decimal ascii converter
`timescale 1ns / 1ps
module tb_signed_int_to_decimal_ascii_top;
	import sida_pkg::*;

	localparam int VBITS = VALUE_BITS_DEF;
	localparam int RADIX = 10;
	localparam int IDLE_PCT = 24;

	// one expected output character
	typedef struct packed {
		logic [7:0] code;
		logic       tail;
	} text_char_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [VBITS-1:0] s_tdata = '0;   // value
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;        // character
	logic             m_tlast;

	text_char_t pending_chars[$];
	int         mismatches = 0;
	bit         tx_gaps = 1'b0;
	bit         rx_stalls = 1'b0;

	signed_int_to_decimal_ascii_top #(.VALUE_BITS(VBITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// decimal text of one value, sign first, most significant digit first
	task automatic predict_text(input logic [VBITS-1:0] value);
		bit               neg;
		logic [VBITS-1:0] mag;
		logic [7:0]       digs[$];
		int               i;
		text_char_t       c;
		neg = value[VBITS-1];
		mag = neg ? (~value + 1'b1) : value;
		do begin
			digs.push_back(8'(mag % RADIX));
			mag = mag / RADIX;
		end while (mag != '0);
		if (neg) begin
			c.code = CHAR_MINUS;
			c.tail = 1'b0;
			pending_chars.push_back(c);
		end
		for (i = digs.size() - 1; i >= 0; i--) begin
			c.code = CHAR_ZERO + digs[i];
			c.tail = (i == 0);
			pending_chars.push_back(c);
		end
	endtask

	// receiver backpressure
	always @(negedge clk) begin
		m_tready <= rx_stalls ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
	end

	// compare every output transaction with the oldest expected character
	always @(posedge clk) begin
		text_char_t exp_c;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character: actual code=%0d last=%0b",
					$time, m_tdata, m_tlast);
				mismatches++;
			end else begin
				exp_c = pending_chars.pop_front();
				if (m_tdata !== exp_c.code) begin
					$display("%0t: character mismatch: expected %0d actual %0d",
						$time, exp_c.code, m_tdata);
					mismatches++;
				end
				if (m_tlast !== exp_c.tail) begin
					$display("%0t: last flag mismatch: expected %0b actual %0b",
						$time, exp_c.tail, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// one input transaction, with optional idle cycles in front
	task automatic send_value(input logic [VBITS-1:0] value);
		@(negedge clk);
		while (tx_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		predict_text(value);
	endtask

	// random value: full range, small, random digit count, or near a power of ten
	function automatic logic [VBITS-1:0] pick_value();
		logic [VBITS-1:0] p10;
		logic [VBITS-1:0] mag;
		int               k;
		p10 = 1;
		k = $urandom_range(0, 9);
		repeat (k) p10 = p10 * RADIX;
		case ($urandom_range(0, 3))
			0: mag = $urandom;
			1: mag = $urandom_range(0, 200) - 100;
			2: mag = $urandom_range(0, 32'h7fff_ffff) % p10;
			default: mag = p10 + $urandom_range(0, 2) - 1;
		endcase
		if ($urandom_range(0, 1) == 1) mag = ~mag + 1'b1;
		if ($urandom_range(0, 49) == 0) mag = {1'b1, {(VBITS-1){1'b0}}};
		return mag;
	endfunction

	// extremes, zero, single digits and digit count boundaries
	task automatic test_directed();
		logic [VBITS-1:0] dir_vals[$];
		dir_vals = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
			32'd99, 32'd100, -32'sd100, 32'd999999999, 32'd1000000000,
			-32'sd1000000000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
			32'h7fff_fffe, 32'hffff_fffe, 32'h5555_5555, 32'haaaa_aaaa,
			32'd1234567890, -32'sd987654321};
		foreach (dir_vals[i]) send_value(dir_vals[i]);
	endtask

	// back-to-back values with neither side idling
	task automatic test_streaming(input int count);
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		repeat (count) send_value(pick_value());
	endtask

	// random values with idle cycles on both sides
	task automatic test_random_idle(input int count);
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		repeat (count) send_value(pick_value());
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_idle(120);
		test_streaming(60);
		test_random_idle(170);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_chars.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
